// File: hdl/rgbkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbkc_pkg
// Shared types, register indexes and coefficient lookup for the RGB kernel
// convolution block.
// ----------------------------------------------------------------------------
package rgbkc_pkg;

  localparam int NUM_CHANNELS = 3;

  localparam logic [2:0] REG_KROW0   = 3'd0;
  localparam logic [2:0] REG_KROW1   = 3'd1;
  localparam logic [2:0] REG_KROW2   = 3'd2;
  localparam logic [2:0] REG_ANC_COL = 3'd3;
  localparam logic [2:0] REG_ANC_ROW = 3'd4;
  localparam logic [2:0] REG_DIVISOR = 3'd5;
  localparam logic [2:0] REG_BIAS    = 3'd6;
  localparam logic [2:0] REG_WIDTH   = 3'd7;

  // Sequencer to lane controls.
  typedef struct packed {
    logic clr;
    logic cen_ld;
    logic mac_en;
    logic tap_valid;
    logic div_start;
  } lane_ctl_t;

  // Signed coefficient for kernel x index i, y index j; zero past index two.
  function automatic logic signed [7:0] coeff(input logic [23:0] kr0,
                                              input logic [23:0] kr1,
                                              input logic [23:0] kr2,
                                              input logic [2:0]  i,
                                              input logic [2:0]  j);
    logic [23:0] row;
    logic [7:0]  b;
    row = 24'd0;
    b   = 8'd0;
    case (i)
      3'd0:    row = kr0;
      3'd1:    row = kr1;
      3'd2:    row = kr2;
      default: row = 24'd0;
    endcase
    case (j)
      3'd0:    b = row[7:0];
      3'd1:    b = row[15:8];
      3'd2:    b = row[23:16];
      default: b = 8'd0;
    endcase
    return $signed(b);
  endfunction

endpackage
`default_nettype wire

// File: hdl/rgbkc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbkc_lane
// One color channel: multiply-accumulate over the kernel taps, then a
// restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rgbkc_lane #(
  parameter int SUM_W = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rgbkc_pkg::lane_ctl_t    ctl,
  input  wire logic signed [7:0]       coeff,
  input  wire logic [7:0]              sample,
  input  wire logic [7:0]              divisor,
  output logic                         busy,
  output logic signed [SUM_W-1:0]      quo
);

  localparam int MW = SUM_W - 1;
  localparam int CNW = $clog2(MW + 1);

  logic signed [SUM_W-1:0] acc_r;
  logic [7:0]              cen_r;
  logic [MW-1:0]           dvd_r;
  logic [7:0]              rem_r;
  logic [7:0]              dsr_r;
  logic [CNW-1:0]          cnt_r;
  logic                    busy_r;
  logic                    neg_r;

  logic signed [16:0]      prod;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] mag_s;
  logic [8:0]              r2;
  logic                    qbit;

  always_comb begin
    prod  = 17'(coeff) * 17'($signed({1'b0, sample}));
    term  = ctl.tap_valid ? SUM_W'(prod) : SUM_W'($signed({1'b0, cen_r}));
    mag_s = acc_r[SUM_W-1] ? -acc_r : acc_r;
    r2    = {rem_r, dvd_r[MW-1]};
    qbit  = (r2 >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (ctl.div_start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.mac_en) begin
      acc_r <= acc_r + term;
    end
    if (ctl.cen_ld) begin
      cen_r <= sample;
    end
    if (ctl.div_start) begin
      dvd_r <= MW'(mag_s);
      rem_r <= 8'd0;
      neg_r <= acc_r[SUM_W-1];
      dsr_r <= (divisor == 8'd0) ? 8'd1 : divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? 8'(r2 - {1'b0, dsr_r}) : r2[7:0];
      dvd_r <= {dvd_r[MW-2:0], qbit};
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule
`default_nettype wire

// File: hdl/rgbkc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbkc_merge
// Combines the three lane quotients: bias add, clamp to 0..255, pack with
// alpha into the output register.
// ----------------------------------------------------------------------------
module rgbkc_merge #(
  parameter int SUM_W = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    ld,
  input  wire logic signed [SUM_W-1:0] q_red,
  input  wire logic signed [SUM_W-1:0] q_green,
  input  wire logic signed [SUM_W-1:0] q_blue,
  input  wire logic [8:0]              bias,
  input  wire logic [7:0]              alpha,
  input  wire logic                    out_tready,
  output logic                         out_tvalid,
  output logic [31:0]                  out_tdata
);

  localparam int VW = SUM_W + 1;

  logic        vld_r;
  logic [31:0] dat_r;

  function automatic logic [7:0] clamp(input logic signed [SUM_W-1:0] q,
                                       input logic [8:0] b);
    logic signed [VW-1:0] v;
    v = VW'(q) + VW'($signed(b));
    if (v < 0) begin
      return 8'd0;
    end else if (v > VW'(255)) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
    if (ld) begin
      dat_r <= {alpha, clamp(q_blue, bias), clamp(q_green, bias), clamp(q_red, bias)};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;

endmodule
`default_nettype wire

// File: hdl/rgb_kernel_convolution.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_kernel_convolution
// KERNEL_SIZE x KERNEL_SIZE convolution over an RGBA raster stream.
//
// in_*: pixel transfers (tuser=0) or drain transfers (tuser=1). out_*: one
// filtered pixel per result. cfg_*: APB-style register port, pready always
// high, registers at byte address 4*i; write only while idle.
// A pixel is stored in the window memory on its transfer. Once all forward
// neighbors of the oldest pending pixel are in, a result is computed: three
// lanes (R, G, B) read the taps one per cycle from the single window read
// port (1 + KERNEL_SIZE^2 reads), then run a restoring divider, one bit per
// cycle (SUM_W-1 steps). The next transfer is taken once the block is
// idle again; an item with no result does not drop in_tready. in_tready
// is low while a result is being made. The result sits in an output
// register; a stalled receiver holds the next result in its final step
// until that register empties.
// Reset clears the counters and draining flag; the window memory needs none.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_PIXELS  = 4194304
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // in_red, in_green, in_blue, in_alpha
  input  wire logic [0:0]  in_tuser,    // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // out_red, out_green, out_blue, out_alpha
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int DEPTH = 2 * (KERNEL_SIZE - 1) * (MAX_WIDTH + 1) + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_PIXELS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int OW    = WW + 5;
  localparam int QW    = ((CW > OW) ? CW : OW) + 2;
  localparam int ADW   = ((AW > OW) ? AW : OW) + 2;
  localparam int IW    = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
  localparam int SUM_W = $clog2(KERNEL_SIZE * KERNEL_SIZE * 32640 + 1) + 1;
  localparam logic [2:0] KM1 = 3'(KERNEL_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CENT, S_TAP, S_LAST, S_DST, S_DIV, S_OUT
  } state_t;

  // configuration
  logic [23:0] kr0_r, kr1_r, kr2_r;
  logic [1:0]  ac_r, ar_r;
  logic [7:0]  div_r;
  logic [8:0]  bias_r;
  logic [10:0] wid_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kr0_r  <= 24'd0;
      kr1_r  <= 24'd65536;
      kr2_r  <= 24'd0;
      ac_r   <= 2'd1;
      ar_r   <= 2'd1;
      div_r  <= 8'd1;
      bias_r <= 9'd0;
      wid_r  <= 11'd640;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgbkc_pkg::REG_KROW0:   kr0_r  <= cfg_pwdata[23:0];
        rgbkc_pkg::REG_KROW1:   kr1_r  <= cfg_pwdata[23:0];
        rgbkc_pkg::REG_KROW2:   kr2_r  <= cfg_pwdata[23:0];
        rgbkc_pkg::REG_ANC_COL: ac_r   <= cfg_pwdata[1:0];
        rgbkc_pkg::REG_ANC_ROW: ar_r   <= cfg_pwdata[1:0];
        rgbkc_pkg::REG_DIVISOR: div_r  <= cfg_pwdata[7:0];
        rgbkc_pkg::REG_BIAS:    bias_r <= cfg_pwdata[8:0];
        rgbkc_pkg::REG_WIDTH:   wid_r  <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rgbkc_pkg::REG_KROW0:   cfg_prdata = {8'd0, kr0_r};
      rgbkc_pkg::REG_KROW1:   cfg_prdata = {8'd0, kr1_r};
      rgbkc_pkg::REG_KROW2:   cfg_prdata = {8'd0, kr2_r};
      rgbkc_pkg::REG_ANC_COL: cfg_prdata = {30'd0, ac_r};
      rgbkc_pkg::REG_ANC_ROW: cfg_prdata = {30'd0, ar_r};
      rgbkc_pkg::REG_DIVISOR: cfg_prdata = {24'd0, div_r};
      rgbkc_pkg::REG_BIAS:    cfg_prdata = {23'd0, bias_r};
      rgbkc_pkg::REG_WIDTH:   cfg_prdata = {21'd0, wid_r};
      default:                cfg_prdata = 32'd0;
    endcase
  end

  // effective geometry
  logic [12:0]   wid_x;
  logic [WW-1:0] w_eff;
  logic [2:0]    ac_eff, ar_eff;
  logic [WW+2:0] fwd_y;
  logic [QW-1:0] fwd;

  always_comb begin
    wid_x  = {2'b00, wid_r};
    if (wid_x == 13'd0) begin
      w_eff = WW'(1);
    end else if (wid_x > 13'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wid_x);
    end
    ac_eff = ({1'b0, ac_r} > KM1) ? KM1 : {1'b0, ac_r};
    ar_eff = ({1'b0, ar_r} > KM1) ? KM1 : {1'b0, ar_r};
    fwd_y  = {WW'(0), KM1 - ar_eff} * {3'b000, w_eff};
    fwd    = QW'(KM1 - ac_eff) + QW'(fwd_y);
  end

  // stream state
  state_t        state_r;
  logic [CW-1:0] rcv_r, emt_r;
  logic          drn_r;
  logic [AW-1:0] wr_r, ep_r;
  logic [CW-1:0] p_r, rn_r;
  logic [AW-1:0] eps_r;
  logic [IW-1:0] i_r, j_r;
  logic          mac_pend_r, tv_r, cen_ld_r;
  logic signed [7:0] cf_r;
  logic [7:0]    alpha_r;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;

  logic          acc, drain, restart, pix_ok, emit;
  logic [CW-1:0] rcv_base, rcv_new, emt_base;
  logic [AW-1:0] wr_base, ep_base;
  logic          out_space, mrg_ld, lane_busy;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? AW'(0) : AW'(p + 1'b1);
  endfunction

  always_comb begin
    acc      = in_tvalid & in_tready;
    drain    = in_tuser[0];
    restart  = drn_r & ~drain;
    rcv_base = restart ? CW'(0) : rcv_r;
    emt_base = restart ? CW'(0) : emt_r;
    wr_base  = restart ? AW'(0) : wr_r;
    ep_base  = restart ? AW'(0) : ep_r;
    pix_ok   = ~drain && (QW'(rcv_base) < QW'(MAX_PIXELS));
    rcv_new  = rcv_base + CW'(pix_ok);
    if (drain) begin
      emit = (emt_r < rcv_r);
    end else begin
      emit = pix_ok && (QW'(rcv_new) > QW'(emt_base) + fwd);
    end
  end

  // tap address and bounds
  logic [2:0]           i3, j3;
  logic signed [3:0]    dx, dy;
  logic signed [OW-1:0] dy_x, w_x, off;
  logic signed [QW-1:0] q;
  logic signed [ADW-1:0] a;
  logic                 tap_ok;
  logic signed [7:0]    tap_cf;
  logic                 last_tap;

  always_comb begin
    i3     = 3'(i_r);
    j3     = 3'(j_r);
    dx     = $signed({1'b0, i3}) - $signed({1'b0, ac_eff});
    dy     = $signed({1'b0, j3}) - $signed({1'b0, ar_eff});
    dy_x   = OW'(dy);
    w_x    = OW'($signed({1'b0, w_eff}));
    off    = OW'(dx) + OW'(dy_x * w_x);
    q      = QW'($signed({1'b0, p_r})) + QW'(off);
    tap_ok = (q >= 0) && (q < QW'($signed({1'b0, rn_r})));
    a      = ADW'($signed({1'b0, eps_r})) + ADW'(off);
    if (a < 0) begin
      a = a + ADW'(DEPTH);
    end else if (a >= ADW'(DEPTH)) begin
      a = a - ADW'(DEPTH);
    end
    tap_cf   = rgbkc_pkg::coeff(kr0_r, kr1_r, kr2_r, i3, j3);
    last_tap = (i_r == IW'(KERNEL_SIZE - 1)) && (j_r == IW'(KERNEL_SIZE - 1));
    rd_addr  = (state_r == S_CENT) ? eps_r : AW'(a);
    out_space = ~out_tvalid | out_tready;
    mrg_ld    = (state_r == S_OUT) && out_space;
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (acc && pix_ok) begin
      mem[wr_base] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rcv_r      <= '0;
      emt_r      <= '0;
      drn_r      <= 1'b0;
      wr_r       <= '0;
      ep_r       <= '0;
      mac_pend_r <= 1'b0;
      cen_ld_r   <= 1'b0;
    end else begin
      mac_pend_r <= (state_r == S_TAP);
      cen_ld_r   <= (state_r == S_CENT);
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            drn_r <= drain;
            rcv_r <= rcv_new;
            wr_r  <= pix_ok ? ptr_inc(wr_base) : wr_base;
            emt_r <= emit ? CW'(emt_base + 1'b1) : emt_base;
            ep_r  <= emit ? ptr_inc(ep_base) : ep_base;
            if (emit) begin
              state_r <= S_CENT;
            end
          end
        end
        S_CENT: state_r <= S_TAP;
        S_TAP: begin
          if (last_tap) begin
            state_r <= S_LAST;
          end
        end
        S_LAST: state_r <= S_DST;
        S_DST:  state_r <= S_DIV;
        S_DIV: begin
          if (!lane_busy) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_space) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && acc && emit) begin
      p_r   <= emt_base;
      eps_r <= ep_base;
      rn_r  <= rcv_new;
    end
    if (state_r == S_CENT) begin
      i_r <= '0;
      j_r <= '0;
    end else if (state_r == S_TAP) begin
      if (j_r == IW'(KERNEL_SIZE - 1)) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    tv_r <= tap_ok;
    cf_r <= tap_cf;
    if (cen_ld_r) begin
      alpha_r <= rd_data_r[31:24];
    end
  end

  rgbkc_pkg::lane_ctl_t lane_ctl;

  always_comb begin
    lane_ctl.clr       = (state_r == S_CENT);
    lane_ctl.cen_ld    = cen_ld_r;
    lane_ctl.mac_en    = mac_pend_r;
    lane_ctl.tap_valid = tv_r;
    lane_ctl.div_start = (state_r == S_DST);
  end

  logic signed [SUM_W-1:0] quo [rgbkc_pkg::NUM_CHANNELS];
  logic [rgbkc_pkg::NUM_CHANNELS-1:0] busy_v;

  for (genvar c = 0; c < rgbkc_pkg::NUM_CHANNELS; c++) begin : g_lane
    rgbkc_lane #(.SUM_W(SUM_W)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .coeff   (cf_r),
      .sample  (rd_data_r[8*c +: 8]),
      .divisor (div_r),
      .busy    (busy_v[c]),
      .quo     (quo[c])
    );
  end

  assign lane_busy = |busy_v;

  rgbkc_merge #(.SUM_W(SUM_W)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (mrg_ld),
    .q_red      (quo[0]),
    .q_green    (quo[1]),
    .q_blue     (quo[2]),
    .bias       (bias_r),
    .alpha      (alpha_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  a_wr_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r <= AW'(DEPTH - 1)) && (ep_r <= AW'(DEPTH - 1)))
    else $error("window pointer out of range");

  a_emt_le_rcv: assert property (@(posedge clk) disable iff (!rst_n) emt_r <= rcv_r)
    else $error("emitted count passed received count");

  a_ld_space: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_ld |-> !(out_tvalid && !out_tready))
    else $error("output register overwritten");

  a_busy_div: assert property (@(posedge clk) disable iff (!rst_n)
    lane_busy |-> (state_r == S_DIV))
    else $error("lanes dividing outside divide step");

endmodule
`default_nettype wire
